### rtl/i2c_master_bit_engine_defines.svh
// Assertion macros used by the checker file.
`ifndef I2C_MASTER_BIT_ENGINE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define I2CM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2cm assertion failed");

// Next-cycle implication, disabled during reset.
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2cm assertion failed");

`endif

### rtl/i2cm_pkg.sv
// ---------------------------------------------------------------------------
// i2cm_pkg
// Types, codes and phase constants of the two-wire bus master bit engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  localparam int BITS_PER_BYTE = 8;

  // Phase list layout
  localparam int WR_BASE      = 3 * BITS_PER_BYTE;
  localparam int RD_BASE      = 3 + 4 * BITS_PER_BYTE;
  localparam int START_PHASES = 4;
  localparam int STOP_PHASES  = 3;
  localparam int WRITE_PHASES = WR_BASE + 4;
  localparam int READ_PHASES  = RD_BASE + 3;

  localparam logic [7:0] PHASE_TICKS_RST = 8'd5;

  // Command codes on the input channel
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] write_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic [7:0] read_data;
    logic       read_valid;
    logic       rejected;
  } out_item_t;

  typedef logic [7:0] cfg_item_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] phase;
    logic [7:0] hold;
    logic [7:0] shift;
    logic       scl;
    logic       sda;
    logic       dir;
  } engine_state_t;

endpackage

`default_nettype wire

### rtl/i2cm_chan_if.sv
// ---------------------------------------------------------------------------
// i2cm_chan_if
// Valid/ready channel carrying one payload of type T per transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface i2cm_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/i2cm_step.sv
// ---------------------------------------------------------------------------
// i2cm_step
// Next-state and result logic for one tick of the bit engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cm_step (
  input  i2cm_pkg::engine_state_t state_i,
  input  i2cm_pkg::in_item_t      item_i,
  input  logic [7:0]              phase_ticks_i,
  output i2cm_pkg::engine_state_t state_o,
  output i2cm_pkg::out_item_t     result_o
);

  // p mod 3 for a 6-bit phase number: weights of 2^i mod 3 are 1,2,1,2,...
  function automatic logic [1:0] mod3(input logic [5:0] p);
    logic [3:0] s;
    s = {3'd0, p[0]} + {2'd0, p[1], 1'b0} + {3'd0, p[2]} + {2'd0, p[3], 1'b0}
      + {3'd0, p[4]} + {2'd0, p[5], 1'b0};
    if (s >= 4'd6) s = s - 4'd6;
    if (s >= 4'd3) s = s - 4'd3;
    return s[1:0];
  endfunction

  function automatic logic [5:0] phase_count(input i2cm_pkg::op_t op);
    logic [5:0] n;
    case (op)
      i2cm_pkg::OP_START: n = 6'(i2cm_pkg::START_PHASES);
      i2cm_pkg::OP_STOP:  n = 6'(i2cm_pkg::STOP_PHASES);
      i2cm_pkg::OP_WRITE: n = 6'(i2cm_pkg::WRITE_PHASES);
      i2cm_pkg::OP_READ:  n = 6'(i2cm_pkg::READ_PHASES);
      default:            n = 6'd0;
    endcase
    return n;
  endfunction

  function automatic i2cm_pkg::engine_state_t enter_phase(
    input i2cm_pkg::engine_state_t s,
    input logic [5:0]              p,
    input logic                    sda
  );
    i2cm_pkg::engine_state_t n;
    logic [5:0] pr;
    n  = s;
    pr = p - 6'd3;
    case (s.op)
      i2cm_pkg::OP_START: begin
        if (p == 6'd0) begin
          n.dir = 1'b1;
          n.scl = 1'b1;
        end else if (p == 6'd1) begin
          n.sda = 1'b1;
        end else if (p == 6'd2) begin
          n.sda = 1'b0;
        end else begin
          n.scl = 1'b0;
        end
      end
      i2cm_pkg::OP_STOP: begin
        if (p == 6'd0) begin
          n.dir = 1'b1;
          n.sda = 1'b0;
        end else if (p == 6'd1) begin
          n.scl = 1'b1;
        end else begin
          n.sda = 1'b1;
        end
      end
      i2cm_pkg::OP_WRITE: begin
        if (p < 6'(i2cm_pkg::WR_BASE)) begin
          case (mod3(p))
            2'd0: begin
              n.dir = 1'b1;
              n.sda = s.shift[7];
            end
            2'd1: n.scl = 1'b1;
            default: begin
              n.scl   = 1'b0;
              n.shift = {s.shift[6:0], 1'b0};
            end
          endcase
        end else if (p == 6'(i2cm_pkg::WR_BASE + 1)) begin
          n.dir = 1'b0;
          n.scl = 1'b1;
        end else if (p == 6'(i2cm_pkg::WR_BASE + 3)) begin
          n.scl = 1'b0;
        end
        // extra hold and ignored acknowledge sample change nothing
      end
      i2cm_pkg::OP_READ: begin
        if (p == 6'd0) begin
          n.sda = 1'b1;
        end else if (p == 6'd1) begin
          n.dir = 1'b0;
        end else if (p == 6'd2) begin
          n.scl = 1'b0;
        end else if (p < 6'(i2cm_pkg::RD_BASE)) begin
          case (pr[1:0])
            2'd0: n.scl = 1'b1;
            2'd1: n.shift = {s.shift[6:0], 1'b0};
            2'd2: n.shift = {s.shift[7:1], s.shift[0] | sda};
            default: n.scl = 1'b0;
          endcase
        end else if (p == 6'(i2cm_pkg::RD_BASE)) begin
          n.dir = 1'b1;
          n.sda = 1'b1;
        end else if (p == 6'(i2cm_pkg::RD_BASE + 1)) begin
          n.scl = 1'b1;
        end else begin
          n.scl = 1'b0;
        end
      end
      default: n = s;
    endcase
    return n;
  endfunction

  i2cm_pkg::engine_state_t st;
  logic                    request;
  logic [7:0]              reload;
  logic [5:0]              p;
  logic                    rvalid;
  logic [7:0]              rdata;
  logic                    rej;

  always_comb begin
    st      = state_i;
    request = item_i.command inside {[i2cm_pkg::CMD_START : i2cm_pkg::CMD_READ]};
    // a zero setting behaves as one tick
    reload  = (phase_ticks_i == 8'd0) ? 8'd0 : phase_ticks_i - 8'd1;
    p       = state_i.phase + 6'd1;
    rvalid  = 1'b0;
    rdata   = 8'd0;
    rej     = 1'b0;

    if (state_i.op != i2cm_pkg::OP_IDLE) begin
      rej = request;
      if (state_i.hold != 8'd0) begin
        st.hold = state_i.hold - 8'd1;
      end else if (p >= phase_count(state_i.op)) begin
        if (state_i.op == i2cm_pkg::OP_READ) begin
          rvalid = 1'b1;
          rdata  = state_i.shift;
        end
        st.op    = i2cm_pkg::OP_IDLE;
        st.phase = 6'd0;
      end else begin
        st       = enter_phase(state_i, p, item_i.sda_in);
        st.phase = p;
        st.hold  = reload;
      end
    end else if (request) begin
      st.op    = i2cm_pkg::op_t'(item_i.command);
      st.phase = 6'd0;
      if (item_i.command == i2cm_pkg::CMD_WRITE) begin
        st.shift = item_i.write_byte;
      end else if (item_i.command == i2cm_pkg::CMD_READ) begin
        st.shift = 8'd0;
      end
      st      = enter_phase(st, 6'd0, item_i.sda_in);
      st.hold = reload;
    end
  end

  assign state_o             = st;
  assign result_o.scl        = st.scl;
  assign result_o.sda_level  = st.sda;
  assign result_o.sda_drive  = st.dir;
  assign result_o.busy_res   = (st.op != i2cm_pkg::OP_IDLE);
  assign result_o.read_data  = rdata;
  assign result_o.read_valid = rvalid;
  assign result_o.rejected   = rej;

endmodule

`default_nettype wire

### rtl/i2cm_out_fifo.sv
// ---------------------------------------------------------------------------
// i2cm_out_fifo
// Two-entry result queue that decouples the engine from output stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cm_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  i2cm_pkg::out_item_t push_data_i,
  output logic                full_o,
  i2cm_chan_if.source         out_ch
);

  i2cm_pkg::out_item_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full_o  = (count_r == 2'd2);
  assign do_push = push_i && !full_o;
  assign do_pop  = out_ch.valid && out_ch.ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data_i;
    end
  end

  assign out_ch.valid = (count_r != 2'd0);
  assign out_ch.data  = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

### rtl/i2c_master_bit_engine.sv
// ---------------------------------------------------------------------------
// i2c_master_bit_engine
// Two-wire bus master bit engine: one tick per input transfer, one result
// per tick with line levels, busy, read byte and reject flags.
// ---------------------------------------------------------------------------
// Channel  Dir  Payload                                   Transfer when
// in_ch    in   command, write_byte, sda_in               valid && ready
// out_ch   out  scl, sda_level, sda_drive, busy_res,      valid && ready
//               read_data, read_valid, rejected
// cfg_ch   in   phase_ticks (8 bit)                       valid && ready
//
// One tick per cycle while in_ch.ready is high; each result is registered in a
// two-entry output queue when its tick is taken and leaves it in order.
// in_ch.ready drops only while the output queue holds two results.
// cfg_ch.ready is always high.
// Reset (rst_n low, synchronous) sets idle, lines high, driving, 5 ticks.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_bit_engine (
  input  logic        clk,
  input  logic        rst_n,
  i2cm_chan_if.sink   in_ch,
  i2cm_chan_if.source out_ch,
  i2cm_chan_if.sink   cfg_ch
);

  i2cm_pkg::engine_state_t state_r, state_nxt;
  i2cm_pkg::out_item_t     result;
  logic [7:0]              phase_ticks_r;
  logic                    fifo_full;
  logic                    in_xfer;

  assign in_ch.ready  = !fifo_full;
  assign cfg_ch.ready = 1'b1;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  i2cm_step u_step (
    .state_i       (state_r),
    .item_i        (in_ch.data),
    .phase_ticks_i (phase_ticks_r),
    .state_o       (state_nxt),
    .result_o      (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.op    <= i2cm_pkg::OP_IDLE;
      state_r.phase <= 6'd0;
      state_r.hold  <= 8'd0;
      state_r.shift <= 8'd0;
      state_r.scl   <= 1'b1;
      state_r.sda   <= 1'b1;
      state_r.dir   <= 1'b1;
      phase_ticks_r <= i2cm_pkg::PHASE_TICKS_RST;
    end else begin
      if (in_xfer) begin
        state_r <= state_nxt;
      end
      if (cfg_ch.valid) begin
        phase_ticks_r <= cfg_ch.data;
      end
    end
  end

  i2cm_out_fifo u_out_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (in_xfer),
    .push_data_i (result),
    .full_o      (fifo_full),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

### rtl/i2cm_checker.sv
// ---------------------------------------------------------------------------
// i2cm_checker
// Port-level checks on the bit engine, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_master_bit_engine_defines.svh"

module i2cm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input i2cm_pkg::out_item_t out_data
);

  // a stalled result stays put
  `I2CM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  // an empty output queue always takes a tick
  `I2CM_ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)
  // an accepted tick leaves a result waiting on the next cycle
  `I2CM_ASSERT_NEXT(a_tick_gives_result, clk, rst_n, in_valid && in_ready, out_valid)
  // a read completes on the tick the engine goes idle
  `I2CM_ASSERT_IMPLY(a_read_done_idle, clk, rst_n, out_valid && out_data.read_valid, !out_data.busy_res)
  // read byte reads as zero except on its completing tick
  `I2CM_ASSERT_IMPLY(a_rdata_zero, clk, rst_n, out_valid && !out_data.read_valid, out_data.read_data == 8'd0)

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire
